FILE: hdl/kscd_pkg.sv
// Package for the keyboard scancode line decoder.
// Holds the scancode constants, the event kinds, the result record and the key map.
// No dependencies.
`default_nettype none

package kscd_pkg;

	// Field widths
	localparam int unsigned CODE_W = 8;
	localparam int unsigned CHAR_W = 7;
	localparam int unsigned POS_W  = 8;
	localparam int unsigned KIND_W = 3;

	// Default longest line
	localparam int unsigned LINE_MAX_DEF = 255;

	// Scancodes with a special meaning
	localparam logic [CODE_W-1:0] SC_CTRL_DOWN    = 8'h1D;
	localparam logic [CODE_W-1:0] SC_CTRL_UP      = 8'h9D;
	localparam logic [CODE_W-1:0] SC_LSHIFT_DOWN  = 8'h2A;
	localparam logic [CODE_W-1:0] SC_RSHIFT_DOWN  = 8'h36;
	localparam logic [CODE_W-1:0] SC_LSHIFT_UP    = 8'hAA;
	localparam logic [CODE_W-1:0] SC_RSHIFT_UP    = 8'hB6;
	localparam logic [CODE_W-1:0] SC_KEY_C        = 8'h2E;
	localparam logic [CODE_W-1:0] SC_ENTER        = 8'h1C;
	localparam logic [CODE_W-1:0] SC_BACKSPACE    = 8'h0E;

	// Offset from upper to lower case
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'd32;

	// Event kinds on the result channel
	typedef enum logic [KIND_W-1:0] {
		EV_NONE      = 3'd0,
		EV_CHAR      = 3'd1,
		EV_BACKSPACE = 3'd2,
		EV_ENTER     = 3'd3,
		EV_INTERRUPT = 3'd4
	} event_kind_t;

	// One result item
	typedef struct packed {
		event_kind_t       kind;
		logic [CHAR_W-1:0] char_code;
		logic [POS_W-1:0]  line_position;
		logic              char_stored;
	} result_t;

	// Set-1 make code to ASCII, letters in upper case; zero means no character.
	function automatic logic [CHAR_W-1:0] key_char(input logic [CHAR_W-1:0] code);
		logic [CHAR_W-1:0] ch;
		ch = '0;
		unique case (code)
			7'h02: ch = 7'h31;
			7'h03: ch = 7'h32;
			7'h04: ch = 7'h33;
			7'h05: ch = 7'h34;
			7'h06: ch = 7'h35;
			7'h07: ch = 7'h36;
			7'h08: ch = 7'h37;
			7'h09: ch = 7'h38;
			7'h0A: ch = 7'h39;
			7'h0B: ch = 7'h30;
			7'h0C: ch = 7'h2D;
			7'h0D: ch = 7'h3D;
			7'h1E: ch = 7'h41;
			7'h30: ch = 7'h42;
			7'h2E: ch = 7'h43;
			7'h20: ch = 7'h44;
			7'h12: ch = 7'h45;
			7'h21: ch = 7'h46;
			7'h22: ch = 7'h47;
			7'h23: ch = 7'h48;
			7'h17: ch = 7'h49;
			7'h24: ch = 7'h4A;
			7'h25: ch = 7'h4B;
			7'h26: ch = 7'h4C;
			7'h32: ch = 7'h4D;
			7'h31: ch = 7'h4E;
			7'h18: ch = 7'h4F;
			7'h19: ch = 7'h50;
			7'h10: ch = 7'h51;
			7'h13: ch = 7'h52;
			7'h1F: ch = 7'h53;
			7'h14: ch = 7'h54;
			7'h16: ch = 7'h55;
			7'h2F: ch = 7'h56;
			7'h11: ch = 7'h57;
			7'h2D: ch = 7'h58;
			7'h15: ch = 7'h59;
			7'h2C: ch = 7'h5A;
			7'h39: ch = 7'h20;
			7'h33: ch = 7'h2C;
			7'h34: ch = 7'h2E;
			7'h35: ch = 7'h2F;
			default: ch = '0;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/kscd_core.sv
// Decode step of the scancode line decoder: modifier and line-length state plus
// the combinational decision for one scancode. Depends on kscd_pkg.
`default_nettype none

module kscd_core import kscd_pkg::*; #(
	parameter int unsigned LINE_MAX = LINE_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,            // apply this scancode now
	input  wire logic [CODE_W-1:0] scancode,
	input  wire logic              process_running,
	output result_t                res
);

	localparam logic [POS_W-1:0] LINE_LIMIT = POS_W'(LINE_MAX);

	logic             ctrl_held_q;
	logic             shift_held_q;
	logic [POS_W-1:0] line_length_q;

	logic             ctrl_nxt;
	logic             shift_nxt;
	logic [POS_W-1:0] length_nxt;
	logic [CHAR_W-1:0] map_char;
	logic              is_letter;

	assign map_char  = key_char(scancode[CHAR_W-1:0]);
	assign is_letter = (map_char >= 7'h41) && (map_char <= 7'h5A);

	// Modifier updates come first and are seen by the rest of the decision.
	always_comb begin
		ctrl_nxt  = ctrl_held_q;
		shift_nxt = shift_held_q;
		if (scancode == SC_CTRL_DOWN) begin
			ctrl_nxt = 1'b1;
		end
		if (scancode == SC_CTRL_UP) begin
			ctrl_nxt = 1'b0;
		end
		if (scancode == SC_LSHIFT_DOWN || scancode == SC_RSHIFT_DOWN) begin
			shift_nxt = 1'b1;
		end
		if (scancode == SC_LSHIFT_UP || scancode == SC_RSHIFT_UP) begin
			shift_nxt = 1'b0;
		end
	end

	// Event decision in priority order: release, ctrl+C, enter, blocked, backspace, key.
	always_comb begin
		res        = '{kind: EV_NONE, char_code: '0, line_position: '0, char_stored: 1'b0};
		length_nxt = line_length_q;
		if (scancode[CODE_W-1]) begin
			res.kind = EV_NONE;
		end else if (ctrl_nxt && scancode == SC_KEY_C) begin
			res.kind = process_running ? EV_INTERRUPT : EV_NONE;
		end else if (scancode == SC_ENTER) begin
			res.kind          = EV_ENTER;
			res.line_position = line_length_q;
			length_nxt        = '0;
		end else if (process_running) begin
			res.kind = EV_NONE;
		end else if (scancode == SC_BACKSPACE) begin
			if (line_length_q != '0) begin
				res.kind   = EV_BACKSPACE;
				length_nxt = line_length_q - POS_W'(1);
			end
		end else if (map_char != '0) begin
			res.kind          = EV_CHAR;
			res.char_code     = (!shift_nxt && is_letter) ? (map_char + CASE_OFFSET) : map_char;
			res.line_position = line_length_q;
			if (line_length_q < LINE_LIMIT) begin
				res.char_stored = 1'b1;
				length_nxt      = line_length_q + POS_W'(1);
			end
		end
	end

	// Held state and line length advance once per processed beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_held_q   <= 1'b0;
			shift_held_q  <= 1'b0;
			line_length_q <= '0;
		end else if (fire) begin
			ctrl_held_q   <= ctrl_nxt;
			shift_held_q  <= shift_nxt;
			line_length_q <= length_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/keyboard_scancode_line_decoder.sv
// Top level of the keyboard scancode line decoder: input register, decode step
// and result register. Depends on kscd_pkg and kscd_core.
//
//  Channel   Dir  Payload
//  s_axis    in   tdata[7:0] scancode, tdata[8] process_running
//  m_axis    out  tdata[6:0] char_code, [14:7] line_position, [15] char_stored;
//                 tuser[2:0] event_kind
//
// One beat in and one beat out per cycle while m_axis does not stall; a beat passes
// the input register, then the single decode step, then the result register.
// Reset clears the held modifiers, the line length and both valid flags.
// A stall on m_axis holds the result; one more beat waits in the input
// register, after which s_axis_tready drops until the result is taken.
`default_nettype none

module keyboard_scancode_line_decoder import kscd_pkg::*; #(
	parameter int unsigned LINE_MAX = LINE_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [7:0] scancode, [8] process_running
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [15:0] m_axis_tdata,   // [6:0] char_code, [14:7] line_position,
	                                          // [15] char_stored
	output      logic [2:0]  m_axis_tuser    // [2:0] event_kind
);

	logic              valid_s1;
	logic [CODE_W-1:0] scancode_s1;
	logic              running_s1;
	logic              advance;
	result_t           res;
	result_t           res_q;

	// The stage moves forward when the result register is empty or being drained.
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			scancode_s1 <= s_axis_tdata[7:0];
			running_s1  <= s_axis_tdata[8];
		end
	end

	// Decode step with the held state
	kscd_core #(
		.LINE_MAX (LINE_MAX)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (advance),
		.scancode        (scancode_s1),
		.process_running (running_s1),
		.res             (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tdata = {res_q.char_stored, res_q.line_position, res_q.char_code};
	assign m_axis_tuser = res_q.kind;

endmodule

`default_nettype wire

FILE: verif/tb_keyboard_scancode_line_decoder.sv
// Self-checking testbench for the keyboard scancode line decoder.
// Drives scancode beats with bursty gaps, stalls the result side, and checks each result
// against a local decoder model. Depends on kscd_pkg and keyboard_scancode_line_decoder.
`default_nettype none

module tb_keyboard_scancode_line_decoder;
	import kscd_pkg::*;

	localparam int LINE_MAX     = LINE_MAX_DEF;
	localparam int KEY_COUNT    = 1150;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_PRINTS   = 40;

	// First scancode of each row of character keys, and a few single keys.
	localparam logic [CHAR_W-1:0] ROW_NUM_FIRST    = 7'h02;
	localparam logic [CHAR_W-1:0] ROW_TOP_FIRST    = 7'h10;
	localparam logic [CHAR_W-1:0] ROW_HOME_FIRST   = 7'h1E;
	localparam logic [CHAR_W-1:0] ROW_BOTTOM_FIRST = 7'h2C;
	localparam logic [CHAR_W-1:0] SC_SPACE_KEY     = 7'h39;
	localparam logic [CODE_W-1:0] SC_KEY_A         = 8'h1E;
	localparam logic [CODE_W-1:0] SC_KEY_Z         = 8'h2C;
	localparam logic [CODE_W-1:0] SC_KEY_0         = 8'h0B;
	localparam logic [CODE_W-1:0] SC_KEY_SLASH     = 8'h35;
	localparam logic [CODE_W-1:0] SC_KEY_SPACE     = 8'h39;

	// Receiver stall patterns
	typedef enum int {RX_FREE, RX_COIN, RX_SLOW, RX_MOSTLY} rx_mode_t;

	// One scancode beat, laid out as in tdata[8:0]
	typedef struct packed {
		logic              running;
		logic [CODE_W-1:0] code;
	} key_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	key_beat_t   pending_keys[$];
	result_t     expected_events[$];
	logic [6:0]  mapped_codes[$];
	int          keys_built = 0;
	int          keys_offered = 0;
	int          keys_accepted = 0;
	int          mismatches = 0;
	int          gap_left = 0;
	int          burst_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          rx_cycle = 0;
	rx_mode_t    rx_mode = RX_FREE;

	// Decoder state as seen by the checker
	logic              ctrl_down = 1'b0;
	logic              shift_down = 1'b0;
	logic [POS_W-1:0]  typed_len = '0;

	keyboard_scancode_line_decoder #(.LINE_MAX(LINE_MAX)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Key map built from the keyboard rows; letters come out in upper case.
	function automatic logic [CHAR_W-1:0] ascii_of(input logic [CHAR_W-1:0] code);
		string num_row = "1234567890-=";
		string top_row = "QWERTYUIOP";
		string home_row = "ASDFGHJKL";
		string bottom_row = "ZXCVBNM,./";
		int idx;
		if (code == SC_SPACE_KEY)
			return 7'(" ");
		if (code >= ROW_NUM_FIRST && int'(code - ROW_NUM_FIRST) < num_row.len())
			return 7'(num_row[int'(code - ROW_NUM_FIRST)]);
		if (code >= ROW_TOP_FIRST && int'(code - ROW_TOP_FIRST) < top_row.len())
			return 7'(top_row[int'(code - ROW_TOP_FIRST)]);
		if (code >= ROW_HOME_FIRST && int'(code - ROW_HOME_FIRST) < home_row.len())
			return 7'(home_row[int'(code - ROW_HOME_FIRST)]);
		idx = int'(code) - int'(ROW_BOTTOM_FIRST);
		if (idx >= 0 && idx < bottom_row.len())
			return 7'(bottom_row[idx]);
		return '0;
	endfunction

	// Works out the event for one scancode and updates the held keys and line length.
	function automatic result_t decode_key(input logic [CODE_W-1:0] code, input logic running);
		result_t r;
		logic [CHAR_W-1:0] ch;
		r = '0;
		r.kind = EV_NONE;
		case (code)
			SC_CTRL_DOWN:                   ctrl_down = 1'b1;
			SC_CTRL_UP:                     ctrl_down = 1'b0;
			SC_LSHIFT_DOWN, SC_RSHIFT_DOWN: shift_down = 1'b1;
			SC_LSHIFT_UP, SC_RSHIFT_UP:     shift_down = 1'b0;
			default: ;
		endcase
		if (code[7])
			return r;
		if (ctrl_down && code == SC_KEY_C) begin
			if (running)
				r.kind = EV_INTERRUPT;
			return r;
		end
		if (code == SC_ENTER) begin
			r.kind = EV_ENTER;
			r.line_position = typed_len;
			typed_len = '0;
			return r;
		end
		if (running)
			return r;
		if (code == SC_BACKSPACE) begin
			if (typed_len != '0) begin
				typed_len = typed_len - 1'b1;
				r.kind = EV_BACKSPACE;
			end
			return r;
		end
		ch = ascii_of(code[6:0]);
		if (ch == '0)
			return r;
		if (!shift_down && ch >= 7'("A") && ch <= 7'("Z"))
			ch = ch + CASE_OFFSET;
		r.kind = EV_CHAR;
		r.char_code = ch;
		r.line_position = typed_len;
		if (int'(typed_len) < LINE_MAX) begin
			typed_len = typed_len + 1'b1;
			r.char_stored = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTS)
			$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic push_key(input logic [CODE_W-1:0] code, input logic running);
		key_beat_t k;
		k.running = running;
		k.code = code;
		pending_keys.push_back(k);
		keys_built++;
	endtask

	function automatic logic [CODE_W-1:0] any_char();
		return {1'b0, mapped_codes[$urandom_range(0, mapped_codes.size() - 1)]};
	endfunction

	task automatic toggle_shift();
		case ($urandom_range(0, 3))
			0: push_key(SC_LSHIFT_DOWN, 1'b0);
			1: push_key(SC_RSHIFT_DOWN, 1'b0);
			2: push_key(SC_LSHIFT_UP, 1'b0);
			default: push_key(SC_RSHIFT_UP, 1'b0);
		endcase
	endtask

	// A typed command line with shifts, edits and a stray ctrl+C, closed by enter.
	task automatic type_line();
		int n;
		n = $urandom_range(0, 20);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 11))
				0, 1: toggle_shift();
				2: push_key(SC_BACKSPACE, 1'b0);
				3: begin
					push_key(SC_CTRL_DOWN, 1'b0);
					push_key(SC_KEY_C, 1'b0);
					push_key(SC_CTRL_UP, 1'b0);
				end
				default: push_key(any_char(), 1'b0);
			endcase
		end
		push_key(SC_ENTER, 1'b0);
	endtask

	// Typing while a process runs: only ctrl+C and enter act.
	task automatic run_process();
		int n;
		n = $urandom_range(2, 12);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: push_key(SC_CTRL_DOWN, 1'b1);
				1: push_key(SC_CTRL_UP, 1'b1);
				2: push_key(SC_KEY_C, 1'b1);
				3: push_key(SC_ENTER, 1'b1);
				4: push_key(SC_BACKSPACE, 1'b1);
				default: push_key(any_char(), 1'b1);
			endcase
		end
	endtask

	// Types past the end of the line so that characters are echoed but not stored.
	task automatic fill_line();
		int target;
		int typed;
		target = LINE_MAX + $urandom_range(2, 6);
		typed = 0;
		push_key(SC_CTRL_UP, 1'b0);
		push_key(SC_ENTER, 1'($urandom_range(0, 1)));
		while (typed < target) begin
			if ($urandom_range(0, 15) == 0) begin
				toggle_shift();
			end else begin
				push_key(any_char(), 1'b0);
				typed++;
			end
		end
		push_key(SC_BACKSPACE, 1'b0);
		push_key(any_char(), 1'b0);
		push_key(any_char(), 1'b0);
		push_key(SC_ENTER, 1'b0);
	endtask

	// Clock
	initial begin
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#1_600_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Accepted scancode beats go through the local decoder.
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			expected_events.push_back(decode_key(s_axis_tdata[7:0], s_axis_tdata[8]));
			keys_accepted++;
		end
	end

	// Sender: bursts of beats with random gaps; a beat is held until it is taken.
	always @(negedge clk) begin
		logic      nxt_valid;
		key_beat_t beat;
		nxt_valid = 1'b0;
		beat = s_axis_tdata[8:0];
		if (arst_n) begin
			if (s_axis_tvalid && keys_accepted != keys_offered) begin
				nxt_valid = 1'b1;
			end else if (gap_left != 0) begin
				gap_left--;
			end else if (pending_keys.size() != 0) begin
				if (burst_left == 0)
					burst_left = $urandom_range(1, 32);
				beat = pending_keys.pop_front();
				nxt_valid = 1'b1;
				keys_offered++;
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
						: $urandom_range(0, 2);
			end
		end
		s_axis_tvalid <= nxt_valid;
		s_axis_tdata <= {7'b0, beat};
	end

	// Receiver: changing stall patterns plus one long hold-off that fills the block.
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 64 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && keys_accepted >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE:   m_axis_tready <= 1'b1;
				RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
				RX_SLOW:   m_axis_tready <= (rx_cycle % 4 == 0);
				default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Monitor: each result beat against the oldest expected event.
	always @(posedge clk) begin
		result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("result beat with no event expected, tuser %0d tdata %h",
					m_axis_tuser, m_axis_tdata));
			end else begin
				want = expected_events.pop_front();
				if (m_axis_tuser !== want.kind)
					report_mismatch($sformatf("event_kind %0d, expected %0d",
						m_axis_tuser, want.kind));
				if (m_axis_tdata[6:0] !== want.char_code)
					report_mismatch($sformatf("char_code %h, expected %h",
						m_axis_tdata[6:0], want.char_code));
				if (m_axis_tdata[14:7] !== want.line_position)
					report_mismatch($sformatf("line_position %0d, expected %0d",
						m_axis_tdata[14:7], want.line_position));
				if (m_axis_tdata[15] !== want.char_stored)
					report_mismatch($sformatf("char_stored %b, expected %b",
						m_axis_tdata[15], want.char_stored));
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int fills_done;
		fills_done = 0;
		for (int c = 0; c < 128; c++)
			if (ascii_of(7'(c)) != '0)
				mapped_codes.push_back(7'(c));

		// Directed keys: extremes, modifiers, edits, ctrl+C and enter in both process states.
		push_key(8'h00, 1'b0);
		push_key(8'hFF, 1'b1);
		push_key(SC_KEY_A, 1'b0);
		push_key(SC_LSHIFT_DOWN, 1'b0);
		push_key(SC_KEY_Z, 1'b0);
		push_key(SC_KEY_0, 1'b0);
		push_key(SC_LSHIFT_UP, 1'b0);
		push_key(SC_RSHIFT_DOWN, 1'b0);
		push_key(SC_KEY_SLASH, 1'b0);
		push_key(SC_RSHIFT_UP, 1'b0);
		push_key(SC_KEY_SPACE, 1'b0);
		push_key(SC_BACKSPACE, 1'b0);
		push_key(SC_CTRL_DOWN, 1'b0);
		push_key(SC_KEY_C, 1'b0);
		push_key(SC_KEY_C, 1'b1);
		push_key(SC_KEY_A, 1'b1);
		push_key(SC_BACKSPACE, 1'b1);
		push_key(SC_ENTER, 1'b1);
		push_key(SC_CTRL_UP, 1'b0);
		push_key(SC_KEY_C, 1'b0);
		push_key(SC_BACKSPACE, 1'b0);
		push_key(SC_BACKSPACE, 1'b0);
		push_key(8'h7F, 1'b0);
		push_key(SC_ENTER, 1'b0);
		push_key(8'h80, 1'b0);

		// Random part: mostly typed lines, with two overfilled lines mixed in.
		while (keys_built < KEY_COUNT) begin
			if (fills_done < 2 && keys_built >= (fills_done == 0 ? 150 : 600)) begin
				fill_line();
				fills_done++;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: type_line();
					6, 7: run_process();
					default: begin
						for (int i = $urandom_range(1, 8); i > 0; i--)
							push_key(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					end
				endcase
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_keys.size() != 0 || keys_accepted != keys_offered)
			@(posedge clk);
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
